[design/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// assertion shorthands included by audio_frame_master_clock
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, disabled while reset is asserted
`define AFMC_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion, checked during reset too
`define AFMC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[design/afmc_pkg.sv]
// ----------------------------------------------------------------------------
// afmc_pkg
// shared widths, request codes and defaults of the audio frame clock
// ----------------------------------------------------------------------------
package afmc_pkg;

	localparam int REQ_W    = 3;
	localparam int SEEK_W   = 48;
	localparam int MODE_W   = 2;
	localparam int CNT_W    = 16;
	localparam int TICK_W   = 47;
	localparam int FRAMES_W = 48;
	localparam int RATE_W   = 20;

	// multiplier digit, frames are consumed this many bits per cycle
	localparam int DIGIT_W    = 8;
	localparam int MUL_DIGITS = FRAMES_W / DIGIT_W;

	localparam logic [RATE_W-1:0] RATE_RESET = 20'd48000;

	localparam int unsigned         TICKS_PER_SEC_DEF = 1000000;
	localparam logic [TICK_W-1:0]   MAX_TICK_DEF      = 47'h7FFF_FFFF_FFFF;

	typedef enum logic [REQ_W-1:0] {
		REQ_PLAY   = 3'd0,
		REQ_PAUSE  = 3'd1,
		REQ_SEEK   = 3'd2,
		REQ_FRAMES = 3'd3,
		REQ_QUERY  = 3'd4
	} req_t;

endpackage

[design/afmc_mul.sv]
// ----------------------------------------------------------------------------
// afmc_mul
// digit-serial multiply of the frame count by the tick rate
// ----------------------------------------------------------------------------
module afmc_mul #(
	parameter int unsigned TICKS_PER_SEC = afmc_pkg::TICKS_PER_SEC_DEF,
	parameter int          TPS_W         = 20,
	parameter int          PW            = afmc_pkg::FRAMES_W + 20
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [afmc_pkg::FRAMES_W-1:0] frames,
	output logic                          done,
	output logic [PW-1:0]                 product
);

	localparam int CW = $clog2(afmc_pkg::MUL_DIGITS + 1);
	localparam logic [TPS_W-1:0] TPS_C = TPS_W'(TICKS_PER_SEC);

	logic [afmc_pkg::FRAMES_W-1:0]         fr_q;
	logic [PW-1:0]                         acc_q;
	logic [CW-1:0]                         cnt_q;
	logic                                  busy_q;
	logic                                  done_q;
	logic [afmc_pkg::DIGIT_W+TPS_W-1:0]    partial;

	// most significant digit first, accumulator shifts up one digit per cycle
	assign partial = (afmc_pkg::DIGIT_W+TPS_W)'(fr_q[afmc_pkg::FRAMES_W-1 -: afmc_pkg::DIGIT_W])
		* (afmc_pkg::DIGIT_W+TPS_W)'(TPS_C);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= busy_q && (cnt_q == CW'(1));
			if (start) begin
				cnt_q  <= CW'(afmc_pkg::MUL_DIGITS);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			fr_q  <= frames;
			acc_q <= '0;
		end else if (busy_q) begin
			fr_q  <= fr_q << afmc_pkg::DIGIT_W;
			acc_q <= {acc_q[PW-afmc_pkg::DIGIT_W-1:0], {afmc_pkg::DIGIT_W{1'b0}}}
				+ PW'(partial);
		end
	end

	assign done    = done_q;
	assign product = acc_q;

endmodule

[design/afmc_div.sv]
// ----------------------------------------------------------------------------
// afmc_div
// bit-serial restoring divide of the tick product by the sample rate
// ----------------------------------------------------------------------------
module afmc_div #(
	parameter int PW = afmc_pkg::FRAMES_W + 20
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [PW-1:0]               dividend,
	input  logic [afmc_pkg::RATE_W-1:0] divisor,
	output logic                        done,
	output logic [PW-1:0]               quotient
);

	localparam int CW = $clog2(PW + 1);

	logic [PW-1:0]                 dq_q;
	logic [afmc_pkg::RATE_W-1:0]   rem_q;
	logic [afmc_pkg::RATE_W-1:0]   d_q;
	logic [CW-1:0]                 cnt_q;
	logic                          busy_q;
	logic                          done_q;
	logic [afmc_pkg::RATE_W:0]     trial;
	logic [afmc_pkg::RATE_W:0]     diff;
	logic                          ge;

	// dividend bits leave at the top, quotient bits enter at the bottom
	assign trial = {rem_q, dq_q[PW-1]};
	assign ge    = trial >= {1'b0, d_q};
	assign diff  = trial - {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= busy_q && (cnt_q == CW'(1));
			if (start) begin
				cnt_q  <= CW'(PW);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dq_q  <= dividend;
			rem_q <= '0;
			d_q   <= divisor;
		end else if (busy_q) begin
			dq_q  <= {dq_q[PW-2:0], ge};
			rem_q <= ge ? diff[afmc_pkg::RATE_W-1:0] : trial[afmc_pkg::RATE_W-1:0];
		end
	end

	assign done     = done_q;
	assign quotient = dq_q;

endmodule

[design/audio_frame_master_clock.sv]
// ----------------------------------------------------------------------------
// audio_frame_master_clock
// playback clock driven by rendered audio frames
// ----------------------------------------------------------------------------
// Each input transfer is one event (play, pause, seek, frames rendered or
// query) and yields exactly one output transfer carrying the tick position,
// the playing flag and the mode of the latest seek, all as they stand after
// the event. The elapsed time since the last pause or seek is
// floor(frames * TICKS_PER_SEC / sample_rate), computed exactly: a digit-serial
// multiplier takes the 48-bit frame count eight bits per cycle, then a
// restoring divider produces one quotient bit per cycle over the whole
// product (48 + clog2(TICKS_PER_SEC+1) bits, 68 at the default rate). Events
// are taken one at a time; a finished result waits in the output register,
// so the next event is accepted while it is still unclaimed. A sample rate
// of zero divides as one. The sample rate may be written only while no event
// is in flight.
`include "assert_macros.svh"

module audio_frame_master_clock #(
	parameter int unsigned                         TICKS_PER_SEC = afmc_pkg::TICKS_PER_SEC_DEF,
	parameter logic [afmc_pkg::TICK_W-1:0]         MAX_TICK      = afmc_pkg::MAX_TICK_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,

	// configuration
	input  logic                               cfg_wr_en,
	input  logic [afmc_pkg::RATE_W-1:0]        cfg_wr_data,

	// event channel
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [afmc_pkg::REQ_W-1:0]         req_type,
	input  logic signed [afmc_pkg::SEEK_W-1:0] seek_tick,
	input  logic [afmc_pkg::MODE_W-1:0]        seek_mode,
	input  logic [afmc_pkg::CNT_W-1:0]         frame_count,

	// result channel
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [afmc_pkg::TICK_W-1:0]        current_tick,
	output logic                               is_playing,
	output logic [afmc_pkg::MODE_W-1:0]        recent_seek_mode
);

	localparam int TPS_W = $clog2(longint'(TICKS_PER_SEC) + 1);
	localparam int PW    = afmc_pkg::FRAMES_W + TPS_W;
	localparam int TW    = afmc_pkg::TICK_W;
	localparam int FW    = afmc_pkg::FRAMES_W;

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_START = 6'b000010,
		ST_MUL   = 6'b000100,
		ST_DIV   = 6'b001000,
		ST_SUM   = 6'b010000,
		ST_OUT   = 6'b100000
	} state_t;

	state_t                          state_q;

	// architectural state
	logic [afmc_pkg::RATE_W-1:0]     rate_q;
	logic [TW-1:0]                   base_q;
	logic [FW-1:0]                   frames_q;
	logic                            playing_q;
	logic [afmc_pkg::MODE_W-1:0]     mode_q;
	logic                            pause_q;

	// working registers
	logic [TW-1:0]                   elapsed_q;
	logic [TW-1:0]                   tick_q;

	// output register
	logic                            out_valid_q;
	logic [TW-1:0]                   out_tick_q;
	logic                            out_playing_q;
	logic [afmc_pkg::MODE_W-1:0]     out_mode_q;

	logic                            accept;
	logic                            load_out;
	afmc_pkg::req_t                  req;
	logic [FW:0]                     frames_sum;
	logic [TW-1:0]                   seek_clamped;
	logic [afmc_pkg::RATE_W-1:0]     divisor;
	logic                            mul_done;
	logic [PW-1:0]                   product;
	logic                            div_start;
	logic                            div_done;
	logic [PW-1:0]                   quotient;
	logic [TW:0]                     tick_sum;

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;
	assign load_out = (state_q == ST_OUT) && (!out_valid_q || out_ready);
	assign req      = afmc_pkg::req_t'(req_type);

	// saturating frame accumulation
	assign frames_sum = {1'b0, frames_q} + (FW+1)'(frame_count);

	// negative seek targets land on zero, large ones on the top tick
	always_comb begin
		if (seek_tick[afmc_pkg::SEEK_W-1]) begin
			seek_clamped = '0;
		end else if (seek_tick[TW-1:0] > MAX_TICK) begin
			seek_clamped = MAX_TICK;
		end else begin
			seek_clamped = seek_tick[TW-1:0];
		end
	end

	assign divisor  = (rate_q == '0) ? afmc_pkg::RATE_W'(1) : rate_q;
	assign div_start = (state_q == ST_MUL) && mul_done;
	assign tick_sum  = {1'b0, base_q} + {1'b0, elapsed_q};

	afmc_mul #(
		.TICKS_PER_SEC (TICKS_PER_SEC),
		.TPS_W         (TPS_W),
		.PW            (PW)
	) u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (state_q == ST_START),
		.frames  (frames_q),
		.done    (mul_done),
		.product (product)
	);

	afmc_div #(
		.PW (PW)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (product),
		.divisor  (divisor),
		.done     (div_done),
		.quotient (quotient)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_START;
					end
				end
				ST_START: begin
					state_q <= ST_MUL;
				end
				ST_MUL: begin
					if (mul_done) begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (div_done) begin
						state_q <= ST_SUM;
					end
				end
				ST_SUM: begin
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (load_out) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// clock state: events apply at acceptance, pause folds in once the tick is known
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rate_q    <= afmc_pkg::RATE_RESET;
			base_q    <= '0;
			frames_q  <= '0;
			playing_q <= 1'b0;
			mode_q    <= '0;
			pause_q   <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				rate_q <= cfg_wr_data;
			end
			if (accept) begin
				pause_q <= (req == afmc_pkg::REQ_PAUSE);
				case (req)
					afmc_pkg::REQ_PLAY: begin
						playing_q <= 1'b1;
					end
					afmc_pkg::REQ_PAUSE: begin
						playing_q <= 1'b0;
					end
					afmc_pkg::REQ_SEEK: begin
						base_q   <= seek_clamped;
						frames_q <= '0;
						mode_q   <= seek_mode;
					end
					afmc_pkg::REQ_FRAMES: begin
						// frames rendered while paused are dropped
						if (playing_q) begin
							frames_q <= frames_sum[FW] ? {FW{1'b1}} : frames_sum[FW-1:0];
						end
					end
					default: begin
					end
				endcase
			end else if (load_out && pause_q) begin
				base_q   <= tick_q;
				frames_q <= '0;
			end
		end
	end

	// elapsed and tick, both clamped to the top tick
	always_ff @(posedge clk) begin
		if ((state_q == ST_DIV) && div_done) begin
			elapsed_q <= (quotient > PW'(MAX_TICK)) ? MAX_TICK : quotient[TW-1:0];
		end
		if (state_q == ST_SUM) begin
			tick_q <= (tick_sum > (TW+1)'(MAX_TICK)) ? MAX_TICK : tick_sum[TW-1:0];
		end
	end

	// output register holds the result until the transfer completes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_tick_q    <= tick_q;
			out_playing_q <= playing_q;
			out_mode_q    <= mode_q;
		end
	end

	assign out_valid        = out_valid_q;
	assign current_tick     = out_tick_q;
	assign is_playing       = out_playing_q;
	assign recent_seek_mode = out_mode_q;

	// an accepted event keeps the input closed for the next cycle
	`AFMC_ASSERT(a_accept_closes, clk, arst_n, accept |=> !in_ready, "input open right after a transfer")
	// a fresh result only comes out of the final step
	`AFMC_ASSERT(a_rise_from_out, clk, arst_n, $rose(out_valid) |-> $past(state_q == ST_OUT), "result without final step")
	// a finished product always hands over to the divider
	`AFMC_ASSERT(a_mul_to_div, clk, arst_n, (mul_done && state_q == ST_MUL) |=> state_q == ST_DIV, "product not handed to divider")
	// a pause result leaves the frame count cleared
	`AFMC_ASSERT(a_pause_clears, clk, arst_n, ($rose(out_valid) && $past(pause_q)) |-> frames_q == '0, "pause left frames behind")

endmodule

[verif/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the audio frame master clock
// ----------------------------------------------------------------------------
// Events go in one at a time over the event channel. At each accepted event
// the bench updates its own copy of the clock state and queues the position it
// expects back. The checker pops one expectation per result transfer and
// compares tick, playing flag and seek mode. Directed tests cover the field
// extremes, every request code and the sample rate corner values. Random
// phases follow with the idle mix swapped between the channels, and one
// phase holds the result channel off long enough to back up the block.
// ----------------------------------------------------------------------------
module testbench;

	// spare request codes behave like a query
	localparam logic [afmc_pkg::REQ_W-1:0]    REQ_SPARE_FIRST =
		afmc_pkg::REQ_W'(afmc_pkg::REQ_QUERY + 1);
	localparam logic [afmc_pkg::REQ_W-1:0]    REQ_SPARE_LAST  = '1;
	localparam logic [afmc_pkg::FRAMES_W-1:0] FRAMES_SAT      = '1;
	localparam logic [afmc_pkg::RATE_W-1:0]   RATE_FIELD_MAX  = '1;
	localparam logic [afmc_pkg::RATE_W-1:0]   RATE_TOP        = 20'd768000;
	localparam logic [afmc_pkg::RATE_W-1:0]   RATE_CD         = 20'd44100;
	localparam logic [afmc_pkg::CNT_W-1:0]    CNT_MAX         = '1;
	localparam logic [afmc_pkg::SEEK_W-1:0]   SEEK_MOST_NEG   =
		{1'b1, {(afmc_pkg::SEEK_W-1){1'b0}}};
	localparam logic [afmc_pkg::SEEK_W-1:0]   SEEK_MOST_POS   =
		{1'b0, {(afmc_pkg::SEEK_W-1){1'b1}}};
	localparam int                            PRINT_CAP       = 200;

	typedef struct packed {
		logic [afmc_pkg::TICK_W-1:0] tick;
		logic                        playing;
		logic [afmc_pkg::MODE_W-1:0] mode;
	} position_t;

	logic                                clk;
	logic                                arst_n;
	logic                                cfg_wr_en;
	logic [afmc_pkg::RATE_W-1:0]         cfg_wr_data;
	logic                                in_valid;
	logic                                in_ready;
	logic [afmc_pkg::REQ_W-1:0]          req_type;
	logic signed [afmc_pkg::SEEK_W-1:0]  seek_tick;
	logic [afmc_pkg::MODE_W-1:0]         seek_mode;
	logic [afmc_pkg::CNT_W-1:0]          frame_count;
	logic                                out_valid;
	logic                                out_ready;
	logic [afmc_pkg::TICK_W-1:0]         current_tick;
	logic                                is_playing;
	logic [afmc_pkg::MODE_W-1:0]         recent_seek_mode;

	// bench copy of the clock state and the configured rate
	logic [afmc_pkg::TICK_W-1:0]   pos_base;
	logic [afmc_pkg::FRAMES_W-1:0] frames_run;
	logic                          playing_now;
	logic [afmc_pkg::MODE_W-1:0]   seek_mode_now;
	logic [afmc_pkg::RATE_W-1:0]   rate_now;

	position_t pending_positions[$];
	position_t want_pos;
	int        mismatches;
	int        send_idle_pct;
	int        recv_idle_pct;
	int        stall_left;

	audio_frame_master_clock dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_wr_en        (cfg_wr_en),
		.cfg_wr_data      (cfg_wr_data),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.req_type         (req_type),
		.seek_tick        (seek_tick),
		.seek_mode        (seek_mode),
		.frame_count      (frame_count),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.current_tick     (current_tick),
		.is_playing       (is_playing),
		.recent_seek_mode (recent_seek_mode)
	);

	always #10 clk = ~clk;

	// ------------------------------------------------------------------------
	// position prediction
	// ------------------------------------------------------------------------

	// base plus floor(frames * ticks_per_sec / rate), elapsed and sum both
	// clamped at the top tick; a zero rate divides as one
	function automatic logic [afmc_pkg::TICK_W-1:0] position_now();
		logic [127:0]                product;
		logic [127:0]                quotient;
		logic [afmc_pkg::RATE_W-1:0] divisor;
		logic [63:0]                 sum;
		divisor = rate_now;
		if (divisor == '0)
			divisor = afmc_pkg::RATE_W'(1);
		product  = 128'(frames_run) * 128'(afmc_pkg::TICKS_PER_SEC_DEF);
		quotient = product / 128'(divisor);
		if (quotient > 128'(afmc_pkg::MAX_TICK_DEF))
			quotient = 128'(afmc_pkg::MAX_TICK_DEF);
		sum = 64'(pos_base) + quotient[63:0];
		if (sum > 64'(afmc_pkg::MAX_TICK_DEF))
			sum = 64'(afmc_pkg::MAX_TICK_DEF);
		return sum[afmc_pkg::TICK_W-1:0];
	endfunction

	function automatic void apply_event(logic [afmc_pkg::REQ_W-1:0] req,
			logic [afmc_pkg::SEEK_W-1:0] st, logic [afmc_pkg::MODE_W-1:0] mode,
			logic [afmc_pkg::CNT_W-1:0] cnt);
		logic [afmc_pkg::FRAMES_W:0] grown;
		case (req)
			afmc_pkg::REQ_PLAY: begin
				playing_now = 1'b1;
			end
			afmc_pkg::REQ_PAUSE: begin
				// fold elapsed time into the base, paused or not
				pos_base    = position_now();
				frames_run  = '0;
				playing_now = 1'b0;
			end
			afmc_pkg::REQ_SEEK: begin
				// negative targets land on zero, the rest fit the tick range
				if (st[afmc_pkg::SEEK_W-1])
					pos_base = '0;
				else
					pos_base = st[afmc_pkg::TICK_W-1:0];
				frames_run    = '0;
				seek_mode_now = mode;
			end
			afmc_pkg::REQ_FRAMES: begin
				// frames only count while playing, saturating
				if (playing_now) begin
					grown      = {1'b0, frames_run} + (afmc_pkg::FRAMES_W+1)'(cnt);
					frames_run = grown[afmc_pkg::FRAMES_W] ? FRAMES_SAT
						: grown[afmc_pkg::FRAMES_W-1:0];
				end
			end
			default: begin
			end
		endcase
		pending_positions.push_back('{position_now(), playing_now, seek_mode_now});
	endfunction

	// ------------------------------------------------------------------------
	// result checking
	// ------------------------------------------------------------------------

	task automatic report_mismatch(string what, longint unsigned got,
			longint unsigned want);
		if (mismatches < PRINT_CAP)
			$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
		mismatches++;
	endtask

	// results are sampled at the rising edge, one expectation per transfer
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (pending_positions.size() == 0) begin
				report_mismatch("unexpected result, tick", 64'(current_tick), 64'd0);
			end else begin
				want_pos = pending_positions.pop_front();
				if (current_tick !== want_pos.tick)
					report_mismatch("current_tick", 64'(current_tick), 64'(want_pos.tick));
				if (is_playing !== want_pos.playing)
					report_mismatch("is_playing", 64'(is_playing), 64'(want_pos.playing));
				if (recent_seek_mode !== want_pos.mode)
					report_mismatch("recent_seek_mode", 64'(recent_seek_mode),
						64'(want_pos.mode));
			end
		end
	end

	// result side: random idling, plus a counted hold-off when one is asked for
	always @(negedge clk) begin
		if (stall_left > 0) begin
			stall_left = stall_left - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// ------------------------------------------------------------------------
	// event channel helpers
	// ------------------------------------------------------------------------

	// one event transfer; valid stays up after it until the next call or a
	// call to end_burst
	task automatic send_event(logic [afmc_pkg::REQ_W-1:0] req,
			logic [afmc_pkg::SEEK_W-1:0] st, logic [afmc_pkg::MODE_W-1:0] mode,
			logic [afmc_pkg::CNT_W-1:0] cnt);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid    <= 1'b1;
		req_type    <= req;
		seek_tick   <= st;
		seek_mode   <= mode;
		frame_count <= cnt;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		apply_event(req, st, mode, cnt);
	endtask

	task automatic end_burst();
		@(negedge clk);
		in_valid <= 1'b0;
	endtask

	// sender holds until every queued position has come back
	task automatic drain_positions();
		end_burst();
		while (pending_positions.size() != 0)
			@(posedge clk);
	endtask

	// rate writes only with nothing in flight
	task automatic set_rate(logic [afmc_pkg::RATE_W-1:0] rate);
		drain_positions();
		@(negedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= rate;
		rate_now     = rate;
		@(negedge clk);
		cfg_wr_en   <= 1'b0;
	endtask

	function automatic logic [afmc_pkg::RATE_W-1:0] pick_rate();
		case ($urandom_range(5))
			0:       return RATE_CD;
			1:       return afmc_pkg::RATE_RESET;
			2:       return afmc_pkg::RATE_W'(1);
			3:       return RATE_TOP;
			4:       return RATE_FIELD_MAX;
			default: return afmc_pkg::RATE_W'($urandom_range(RATE_TOP, 1));
		endcase
	endfunction

	function automatic logic [afmc_pkg::SEEK_W-1:0] pick_seek_tick();
		logic [63:0] raw;
		raw = {$urandom, $urandom};
		case ($urandom_range(3))
			0:       return raw[afmc_pkg::SEEK_W-1:0];
			1:       return afmc_pkg::SEEK_W'(raw[23:0]);
			2:       return SEEK_MOST_POS - afmc_pkg::SEEK_W'(raw[15:0]);
			default: return -afmc_pkg::SEEK_W'(raw[15:0]);
		endcase
	endfunction

	function automatic logic [afmc_pkg::CNT_W-1:0] pick_frame_count();
		case ($urandom_range(9))
			0:       return '0;
			1:       return CNT_MAX;
			2:       return afmc_pkg::CNT_W'($urandom_range(64));
			default: return afmc_pkg::CNT_W'($urandom);
		endcase
	endfunction

	// ------------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------------

	// fresh clock: position zero, paused, frames ignored, spare codes inert
	task automatic test_reset_defaults();
		logic [afmc_pkg::REQ_W-1:0] code;
		send_event(afmc_pkg::REQ_QUERY, '0, '0, '0);
		send_event(afmc_pkg::REQ_FRAMES, '0, '0, CNT_MAX);
		for (int i = int'(REQ_SPARE_FIRST); i <= int'(REQ_SPARE_LAST); i++) begin
			code = afmc_pkg::REQ_W'(i);
			send_event(code, SEEK_MOST_POS, '1, CNT_MAX);
		end
		send_event(afmc_pkg::REQ_PAUSE, '0, '0, '0);
		drain_positions();
	endtask

	// every event kind with the payload at its extremes
	task automatic test_clock_events();
		send_event(afmc_pkg::REQ_PLAY, '0, '0, '0);
		send_event(afmc_pkg::REQ_FRAMES, '0, '0, '0);
		send_event(afmc_pkg::REQ_FRAMES, '0, '0, CNT_MAX);
		send_event(afmc_pkg::REQ_FRAMES, '0, '0, afmc_pkg::CNT_W'(1));
		send_event(afmc_pkg::REQ_QUERY, '1, '1, '1);
		send_event(afmc_pkg::REQ_PAUSE, '0, '0, '0);
		// paused frames must not move the clock
		send_event(afmc_pkg::REQ_FRAMES, '0, '0, CNT_MAX);
		send_event(afmc_pkg::REQ_PLAY, '0, '0, '0);
		send_event(afmc_pkg::REQ_FRAMES, '0, '0, 16'd48000);
		send_event(afmc_pkg::REQ_SEEK, SEEK_MOST_NEG, 2'd3, '0);
		send_event(afmc_pkg::REQ_SEEK, SEEK_MOST_POS, 2'd1, '0);
		// at the top tick, more frames must clamp the sum
		send_event(afmc_pkg::REQ_FRAMES, '0, '0, CNT_MAX);
		send_event(afmc_pkg::REQ_PAUSE, '0, '0, '0);
		send_event(afmc_pkg::REQ_SEEK, SEEK_MOST_POS - afmc_pkg::SEEK_W'(1), 2'd2, '0);
		send_event(afmc_pkg::REQ_PLAY, '0, '0, '0);
		send_event(afmc_pkg::REQ_FRAMES, '0, '0, CNT_MAX);
		send_event(afmc_pkg::REQ_SEEK, '1, 2'd2, '0);
		send_event(afmc_pkg::REQ_SEEK, '0, 2'd0, '0);
		send_event(afmc_pkg::REQ_SEEK, afmc_pkg::SEEK_W'(1), 2'd1, '0);
		send_event(afmc_pkg::REQ_PAUSE, '0, '0, '0);
		drain_positions();
	endtask

	// corner rates, zero among them, each with a short play and pause
	task automatic test_rate_settings();
		logic [afmc_pkg::RATE_W-1:0] rates[5];
		rates = '{'0, afmc_pkg::RATE_W'(1), RATE_FIELD_MAX, RATE_TOP, afmc_pkg::RATE_RESET};
		foreach (rates[i]) begin
			set_rate(rates[i]);
			send_event(afmc_pkg::REQ_PLAY, '0, '0, '0);
			send_event(afmc_pkg::REQ_FRAMES, '0, '0, CNT_MAX);
			send_event(afmc_pkg::REQ_QUERY, '0, '0, '0);
			send_event(afmc_pkg::REQ_PAUSE, '0, '0, '0);
		end
		drain_positions();
	endtask

	// mostly playing with frames, sprinkled with pauses, seeks and noise
	task automatic test_random_traffic(int count, int send_pct, int recv_pct);
		logic [afmc_pkg::REQ_W-1:0] req;
		int                         pick;
		set_rate(pick_rate());
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		for (int n = 0; n < count; n++) begin
			pick = $urandom_range(99);
			if (pick < 14)
				req = afmc_pkg::REQ_PLAY;
			else if (pick < 23)
				req = afmc_pkg::REQ_PAUSE;
			else if (pick < 35)
				req = afmc_pkg::REQ_SEEK;
			else if (pick < 80)
				req = afmc_pkg::REQ_FRAMES;
			else if (pick < 92)
				req = afmc_pkg::REQ_QUERY;
			else
				req = afmc_pkg::REQ_W'($urandom_range(REQ_SPARE_LAST, REQ_SPARE_FIRST));
			send_event(req, pick_seek_tick(), afmc_pkg::MODE_W'($urandom),
				pick_frame_count());
		end
		drain_positions();
	endtask

	// result side holds off long while events keep coming, so the block
	// fills and drops in_ready; then the sender waits for everything back
	task automatic test_backpressure();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		send_event(afmc_pkg::REQ_PLAY, '0, '0, '0);
		stall_left = 400;
		for (int n = 0; n < 12; n++)
			send_event(afmc_pkg::REQ_FRAMES, '0, '0, pick_frame_count());
		drain_positions();
		send_event(afmc_pkg::REQ_QUERY, '0, '0, '0);
		drain_positions();
	endtask

	// ------------------------------------------------------------------------
	// sequence
	// ------------------------------------------------------------------------

	initial begin
		clk           = 1'b0;
		arst_n        = 1'b0;
		cfg_wr_en     = 1'b0;
		cfg_wr_data   = '0;
		in_valid      = 1'b0;
		req_type      = afmc_pkg::REQ_QUERY;
		seek_tick     = '0;
		seek_mode     = '0;
		frame_count   = '0;
		out_ready     = 1'b0;
		mismatches    = 0;
		stall_left    = 0;
		send_idle_pct = 10;
		recv_idle_pct = 30;
		pos_base      = '0;
		frames_run    = '0;
		playing_now   = 1'b0;
		seek_mode_now = '0;
		rate_now      = afmc_pkg::RATE_RESET;

		repeat (12) @(negedge clk);
		arst_n = 1'b1;

		test_reset_defaults();
		test_clock_events();
		test_rate_settings();
		test_random_traffic(150, 17, 59);
		test_random_traffic(150, 59, 17);
		test_backpressure();
		test_random_traffic(150, 0, 0);

		// let any stray result show up before judging
		drain_positions();
		repeat (120) @(posedge clk);
		if (mismatches == 0 && pending_positions.size() == 0)
			$display("testbench: PASS");
		else
			$display("testbench: FAIL");
		$finish;
	end

	// hang guard, far beyond the slowest legal run
	initial begin
		#20000000;
		$display("testbench: FAIL");
		$finish;
	end

endmodule

[sim.f]
+incdir+design
design/afmc_pkg.sv
design/afmc_mul.sv
design/afmc_div.sv
design/audio_frame_master_clock.sv
verif/testbench.sv
